// File: rtl/kcl_pkg.sv
package kcl_pkg;

  // Kind of an input request, carried on the input tuser.
  typedef enum logic [1:0] {
    KIND_KEY  = 2'd0,
    KIND_TICK = 2'd1,
    KIND_PASS = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  // Status of a result, carried on the output tuser.
  typedef enum logic [2:0] {
    ST_DIGIT   = 3'd0,
    ST_CORRECT = 3'd1,
    ST_WRONG   = 3'd2,
    ST_ERASED  = 3'd3,
    ST_TOGGLED = 3'd4,
    ST_IGNORED = 3'd5,
    ST_TICK    = 3'd6,
    ST_PASSED  = 3'd7
  } status_e;

  // Configuration register indexes.
  typedef enum logic {
    REG_SAVED_CODE = 1'b0,
    REG_TICKS      = 1'b1
  } reg_e;

  localparam logic [7:0] KEY_STAR = 8'd42;
  localparam logic [7:0] KEY_HASH = 8'd35;
  localparam logic [7:0] KEY_ZERO = 8'd48;
  localparam logic [7:0] KEY_NINE = 8'd57;

  localparam logic [5:0] MINUTES_PER_HOUR = 6'd60;
  localparam logic [4:0] LAST_HOUR        = 5'd23;

  localparam logic [31:0] SAVED_CODE_RST = 32'h2D2D_2D2D;
  localparam logic [15:0] TICKS_RST      = 16'd3665;

  typedef struct packed {
    status_e     status;
    logic [15:0] entry_count;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic        unlocked;
    logic        show_code;
    logic [7:0]  echo_char;
    logic [2:0]  digits_entered;
  } result_t;

endpackage

// File: rtl/keypad_code_lock.sv
// Keypad code lock with an hours:minutes clock.
// Input stream: tuser carries the request kind (key press, timer tick,
// passage), tdata carries the ASCII key, used only for key presses.
// Output stream: exactly one result per request, in order; tuser holds the
// status code and tdata the digit count, echo character, show and unlock
// flags, hour, minute and the entry count.
// The configuration port writes the saved code (index 0) or the ticks per
// minute (index 1) at any edge with cfg_we_i high; write only while idle.
// A request passes one input register, then the key and clock logic feeding
// one result register. Throughput is one request per cycle while the receiver
// keeps up; the lock and clock state between those registers is updated as
// each request passes.
// When the receiver stalls, the input register still takes one more request;
// tready falls only when both registers are full.
// Reset empties both registers, clears the digit count, flags, clock and
// entry count, and loads the code "----" and 3665 ticks per minute.
module keypad_code_lock #(
  parameter int CODE_LENGTH      = 4,
  parameter int ENTRY_COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] key
  input  logic [1:0]  s_axis_tuser,   // [1:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] digits_entered, [10:3] echo_char, [11] show_code, [12] unlocked,
  // [17:13] hour, [23:18] minute, [39:24] entry_count
  output logic [39:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,   // [2:0] status
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [31:0] cfg_wdata_i
);

  logic [31:0]       saved_code_q;
  logic [15:0]       ticks_q;
  logic              in_vld_q;
  kcl_pkg::kind_e    in_kind_q;
  logic [7:0]        in_key_q;
  logic              out_vld_q;
  kcl_pkg::result_t  out_q;
  kcl_pkg::result_t  result;
  logic              advance;
  logic              s_accept;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      saved_code_q <= kcl_pkg::SAVED_CODE_RST;
      ticks_q      <= kcl_pkg::TICKS_RST;
    end else if (cfg_we_i) begin
      unique case (kcl_pkg::reg_e'(cfg_addr_i))
        kcl_pkg::REG_SAVED_CODE: saved_code_q <= cfg_wdata_i;
        kcl_pkg::REG_TICKS:      ticks_q      <= cfg_wdata_i[15:0];
        default:                 saved_code_q <= saved_code_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_accept) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_kind_q <= kcl_pkg::kind_e'(s_axis_tuser);
      in_key_q  <= s_axis_tdata;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  kcl_core #(
    .CODE_LENGTH      (CODE_LENGTH),
    .ENTRY_COUNT_BITS (ENTRY_COUNT_BITS)
  ) u_core (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .step_i             (advance),
    .kind_i             (in_kind_q),
    .key_i              (in_key_q),
    .saved_code_i       (saved_code_q),
    .ticks_per_minute_i (ticks_q),
    .result_o           (result)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {out_q.entry_count, out_q.minute, out_q.hour, out_q.unlocked,
                          out_q.show_code, out_q.echo_char, out_q.digits_entered};

endmodule

// File: rtl/kcl_clock.sv
module kcl_clock (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        tick_i,
  input  logic [15:0] ticks_per_minute_i,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o
);

  logic [15:0] tick_q, tick_d;
  logic [5:0]  minute_q, minute_d;
  logic [4:0]  hour_q, hour_d;
  logic [16:0] tick_inc;
  logic [5:0]  minute_inc;
  logic [4:0]  hour_inc;

  always_comb begin
    tick_inc   = {1'b0, tick_q} + 17'd1;
    minute_inc = minute_q + 6'd1;
    hour_inc   = hour_q + 5'd1;
    tick_d     = tick_q;
    minute_d   = minute_q;
    hour_d     = hour_q;
    if (tick_i) begin
      tick_d = tick_inc[15:0];
      // A zero period still rolls the minute on every tick.
      if (tick_inc >= {1'b0, ticks_per_minute_i}) begin
        tick_d   = '0;
        minute_d = minute_inc;
        if (minute_inc >= kcl_pkg::MINUTES_PER_HOUR) begin
          minute_d = '0;
          hour_d   = (hour_q >= kcl_pkg::LAST_HOUR) ? '0 : hour_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q   <= '0;
      minute_q <= '0;
      hour_q   <= '0;
    end else begin
      tick_q   <= tick_d;
      minute_q <= minute_d;
      hour_q   <= hour_d;
    end
  end

  assign hour_o   = hour_d;
  assign minute_o = minute_d;

endmodule

// File: rtl/kcl_core.sv
module kcl_core #(
  parameter int CODE_LENGTH      = 4,
  parameter int ENTRY_COUNT_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  kcl_pkg::kind_e          kind_i,
  input  logic [7:0]              key_i,
  input  logic [31:0]             saved_code_i,
  input  logic [15:0]             ticks_per_minute_i,
  output kcl_pkg::result_t        result_o
);

  localparam int CntW = $clog2(CODE_LENGTH + 1);
  localparam int CodeExtW = 8 * CODE_LENGTH + 32;

  logic [7:0]                  buf_q [CODE_LENGTH];
  logic [7:0]                  buf_d [CODE_LENGTH];
  logic [CntW-1:0]             cnt_q, cnt_d, cnt_eff, cnt_inc;
  logic                        show_q, show_d;
  logic                        unlock_q, unlock_d;
  logic [ENTRY_COUNT_BITS-1:0] entries_q, entries_d;
  logic [CodeExtW-1:0]         code_ext;
  logic                        is_digit;
  logic                        buf_wr;
  logic                        match;
  logic                        tick;
  logic [7:0]                  echo;
  kcl_pkg::status_e            status;
  logic [4:0]                  hour;
  logic [5:0]                  minute;

  // Characters beyond the fourth compare against zero.
  assign code_ext = {{(8 * CODE_LENGTH){1'b0}}, saved_code_i};
  assign is_digit = (key_i >= kcl_pkg::KEY_ZERO) && (key_i <= kcl_pkg::KEY_NINE);
  // A full buffer is emptied by any key press before the key is handled.
  assign cnt_eff  = (cnt_q >= CntW'(CODE_LENGTH)) ? '0 : cnt_q;
  assign cnt_inc  = cnt_eff + CntW'(1);
  assign buf_wr   = (kind_i == kcl_pkg::KIND_KEY) && is_digit;
  assign tick     = step_i && (kind_i == kcl_pkg::KIND_TICK);

  always_comb begin
    for (int i = 0; i < CODE_LENGTH; i++) begin
      buf_d[i] = (buf_wr && (cnt_eff == CntW'(i))) ? key_i : buf_q[i];
    end
    match = 1'b1;
    for (int i = 0; i < CODE_LENGTH; i++) begin
      if (buf_d[i] != code_ext[8*i +: 8]) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    cnt_d     = cnt_q;
    show_d    = show_q;
    unlock_d  = unlock_q;
    entries_d = entries_q;
    echo      = '0;
    status    = kcl_pkg::ST_IGNORED;
    unique case (kind_i)
      kcl_pkg::KIND_KEY: begin
        cnt_d = cnt_eff;
        priority if (is_digit) begin
          cnt_d = cnt_inc;
          echo  = show_q ? key_i : kcl_pkg::KEY_STAR;
          if (cnt_inc < CntW'(CODE_LENGTH)) begin
            status = kcl_pkg::ST_DIGIT;
          end else if (match) begin
            status   = kcl_pkg::ST_CORRECT;
            unlock_d = 1'b1;
            if (entries_q != {ENTRY_COUNT_BITS{1'b1}}) begin
              entries_d = entries_q + ENTRY_COUNT_BITS'(1);
            end
          end else begin
            status = kcl_pkg::ST_WRONG;
          end
        end else if (key_i == kcl_pkg::KEY_STAR) begin
          show_d = ~show_q;
          status = kcl_pkg::ST_TOGGLED;
        end else if ((key_i == kcl_pkg::KEY_HASH) && (cnt_eff != '0)) begin
          cnt_d  = cnt_eff - CntW'(1);
          status = kcl_pkg::ST_ERASED;
        end else begin
          status = kcl_pkg::ST_IGNORED;
        end
      end
      kcl_pkg::KIND_TICK: status = kcl_pkg::ST_TICK;
      kcl_pkg::KIND_PASS: begin
        unlock_d = 1'b0;
        status   = kcl_pkg::ST_PASSED;
      end
      default: status = kcl_pkg::ST_IGNORED;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (step_i && buf_wr) begin
      buf_q <= buf_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      show_q    <= 1'b0;
      unlock_q  <= 1'b0;
      entries_q <= '0;
    end else if (step_i) begin
      cnt_q     <= cnt_d;
      show_q    <= show_d;
      unlock_q  <= unlock_d;
      entries_q <= entries_d;
    end
  end

  kcl_clock u_clock (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .tick_i             (tick),
    .ticks_per_minute_i (ticks_per_minute_i),
    .hour_o             (hour),
    .minute_o           (minute)
  );

  always_comb begin
    result_o.status         = status;
    result_o.entry_count    = 16'(entries_d);
    result_o.minute         = minute;
    result_o.hour           = hour;
    result_o.unlocked       = unlock_d;
    result_o.show_code      = show_d;
    result_o.echo_char      = echo;
    result_o.digits_entered = 3'(cnt_d);
  end

endmodule
